// ===== rtl/dtfp_pkg.sv =====
package dtfp_pkg;

    localparam int NUM_W = 64;

    // Largest magnitude: 2^63 - 1, and the most negative value
    localparam logic [NUM_W-1:0] MAG_LIMIT = {1'b0, {(NUM_W-1){1'b1}}};
    localparam logic [NUM_W-1:0] NEG_LIMIT = {1'b1, {(NUM_W-1){1'b0}}};

    // ASCII codes the parser recognizes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIGIT,
        OP_MINUS,
        OP_DOT,
        OP_OTHER
    } op_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } phase_t;

    // Classified character as passed from front to back
    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

    // Finished number, sign applied at the output
    typedef struct packed {
        logic [NUM_W-1:0] magnitude;
        logic             negative;
        logic             overflowed;
    } result_t;

endpackage

// ===== rtl/dtfp_queue.sv =====
module dtfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Store an entry on each push transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level past depth");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> !empty)
        else $error("queue empty right after a push transfer");

    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue level not reduced by a pop transfer");

endmodule

// ===== rtl/dtfp_front.sv =====
module dtfp_front (
    input  logic          [7:0] character,
    input  logic                char_valid,
    input  logic                last_char,
    input  logic                push,
    output logic                full,
    input  logic                cmd_full,
    output logic                cmd_push,
    output dtfp_pkg::cmd_t      cmd
);

    import dtfp_pkg::*;

    logic numeral;

    assign numeral = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign full    = cmd_full;

    // Drop characters that are neither real nor end a string
    assign cmd_push = push && (char_valid || last_char);

    // Classify the character into one operation for the back end
    always_comb
    begin
        cmd.last  = last_char;
        cmd.digit = numeral ? 4'(character - CHAR_ZERO) : 4'd0;
        if (!char_valid)
        begin
            cmd.op = OP_NONE;
        end
        else if (numeral)
        begin
            cmd.op = OP_DIGIT;
        end
        else if (character == CHAR_MINUS)
        begin
            cmd.op = OP_MINUS;
        end
        else if (character == CHAR_DOT)
        begin
            cmd.op = OP_DOT;
        end
        else
        begin
            cmd.op = OP_OTHER;
        end
    end

endmodule

// ===== rtl/dtfp_back.sv =====
module dtfp_back #(
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtfp_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output dtfp_pkg::result_t   res
);

    import dtfp_pkg::*;

    localparam int WT_W  = FRAC_BITS + 1;
    localparam int PROD_W = WT_W + 4;

    phase_t           phase_reg, phase_next;
    logic             minus_pending_reg, minus_pending_next;
    logic             negative_reg, negative_next;
    logic [NUM_W-1:0] magnitude_reg, magnitude_next;
    logic [3:0]       frac_count_reg, frac_count_next;
    logic             overflowed_reg, overflowed_next;

    logic [WT_W-1:0]   weight_tbl [16];
    logic              go;
    logic [NUM_W+3:0]  int_sum;
    logic              int_ovf;
    logic [3:0]        frac_count_inc;
    logic              frac_full;
    logic [PROD_W-1:0] frac_prod;
    logic [NUM_W:0]    frac_sum;
    logic              frac_ovf;

    // Fraction weights floor(2^FRAC_BITS / 10^k), fixed at elaboration
    for (genvar k = 0; k < 16; k++)
    begin : g_weight
        localparam logic [WT_W-1:0] W =
            WT_W'((64'd1 << FRAC_BITS) / (64'd10 ** k));
        assign weight_tbl[k] = W;
    end

    // Take the head command unless it ends a string and no result slot is free
    assign go       = !cmd_empty && (!cmd.last || !res_full);
    assign cmd_pop  = go;
    assign res_push = go && cmd.last;

    // Integer step: magnitude * 10 + digit * 2^FRAC_BITS, checked against the limit
    assign int_sum = {1'b0, magnitude_reg, 3'b000}
                   + {3'b000, magnitude_reg, 1'b0}
                   + (NUM_W + 4)'(64'(cmd.digit) << FRAC_BITS);
    assign int_ovf = overflowed_reg || (int_sum > (NUM_W + 4)'(MAG_LIMIT));

    // Fraction step: add digit times the weight of its position
    assign frac_full      = (frac_count_reg >= 4'(MAX_FRAC_DIGITS));
    assign frac_count_inc = frac_count_reg + 4'd1;
    assign frac_prod      = PROD_W'(weight_tbl[frac_count_inc]) * PROD_W'(cmd.digit);
    assign frac_sum       = {1'b0, magnitude_reg} + (NUM_W + 1)'(frac_prod);
    assign frac_ovf       = overflowed_reg || (frac_sum > (NUM_W + 1)'(MAG_LIMIT));

    // Parser state update for one command
    always_comb
    begin
        phase_next         = phase_reg;
        minus_pending_next = minus_pending_reg;
        negative_next      = negative_reg;
        magnitude_next     = magnitude_reg;
        frac_count_next    = frac_count_reg;
        overflowed_next    = overflowed_reg;

        case (phase_reg)
            PH_START:
            begin
                case (cmd.op)
                    OP_DIGIT:
                    begin
                        phase_next      = PH_INT;
                        magnitude_next  = int_ovf ? MAG_LIMIT : int_sum[NUM_W-1:0];
                        overflowed_next = int_ovf;
                    end
                    OP_MINUS:
                    begin
                        phase_next         = PH_INT;
                        minus_pending_next = 1'b1;
                    end
                    OP_DOT:   phase_next = PH_FRAC;
                    OP_OTHER: phase_next = PH_STOP;
                    default:  phase_next = phase_reg;
                endcase
            end
            PH_INT:
            begin
                case (cmd.op)
                    OP_DIGIT:
                    begin
                        if (minus_pending_reg)
                        begin
                            negative_next      = 1'b1;
                            minus_pending_next = 1'b0;
                        end
                        magnitude_next  = int_ovf ? MAG_LIMIT : int_sum[NUM_W-1:0];
                        overflowed_next = int_ovf;
                    end
                    OP_DOT:   phase_next = minus_pending_reg ? PH_STOP : PH_FRAC;
                    OP_MINUS: phase_next = PH_STOP;
                    OP_OTHER: phase_next = PH_STOP;
                    default:  phase_next = phase_reg;
                endcase
            end
            PH_FRAC:
            begin
                case (cmd.op)
                    OP_DIGIT:
                    begin
                        if (!frac_full)
                        begin
                            frac_count_next = frac_count_inc;
                            magnitude_next  = frac_ovf ? MAG_LIMIT : frac_sum[NUM_W-1:0];
                            overflowed_next = frac_ovf;
                        end
                    end
                    OP_MINUS: phase_next = PH_STOP;
                    OP_DOT:   phase_next = PH_STOP;
                    OP_OTHER: phase_next = PH_STOP;
                    default:  phase_next = phase_reg;
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // Result carries the state after this character
        res.magnitude  = magnitude_next;
        res.negative   = negative_next;
        res.overflowed = overflowed_next;

        // End of string: back to the start
        if (cmd.last)
        begin
            phase_next         = PH_START;
            minus_pending_next = 1'b0;
            negative_next      = 1'b0;
            magnitude_next     = '0;
            frac_count_next    = '0;
            overflowed_next    = 1'b0;
        end
    end

    // Hold parser state, advance on each command taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_START;
            minus_pending_reg <= 1'b0;
            negative_reg      <= 1'b0;
            magnitude_reg     <= '0;
            frac_count_reg    <= '0;
            overflowed_reg    <= 1'b0;
        end
        else if (go)
        begin
            phase_reg         <= phase_next;
            minus_pending_reg <= minus_pending_next;
            negative_reg      <= negative_next;
            magnitude_reg     <= magnitude_next;
            frac_count_reg    <= frac_count_next;
            overflowed_reg    <= overflowed_next;
        end
    end

    a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (magnitude_reg == MAG_LIMIT))
        else $error("overflow flag set without clamped magnitude");

    a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (frac_count_reg != '0) |-> (phase_reg == PH_FRAC || phase_reg == PH_STOP))
        else $error("fraction digits counted outside the fraction");

    a_minus_phase: assert property (@(posedge clk) disable iff (!rst_n)
        minus_pending_reg |-> (!negative_reg && (phase_reg == PH_INT || phase_reg == PH_STOP)))
        else $error("pending minus in an impossible parser state");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (phase_reg == PH_START && magnitude_reg == '0 && !overflowed_reg))
        else $error("parser state not cleared after a string end");

endmodule

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Channel   Direction  Handshake            Fields
// input     in         push / full          character, char_valid, last_char
// result    out        pop / empty          value, saturated
//
// One character is taken per cycle while full is low; a result reaches the ports
// through both queues after the transfer of the character that ends its string.
// Each character passes a two-entry command queue, then the combinational parser
// step (a multiply-by-ten add or one weight multiply-add); a string's result goes
// into a two-entry result queue.
// Reset (rst_n low) empties both queues and returns the parser to the start.
// A full result queue holds the parser only at a character that ends a string;
// the command queue then fills and raises full.
module decimal_text_to_fixed_point #(
    parameter int FRAC_BITS       = 32,
    parameter int MAX_FRAC_DIGITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic         [7:0] character,
    input  logic               char_valid,
    input  logic               last_char,
    input  logic               push,
    output logic               full,
    output logic signed [63:0] value,
    output logic               saturated,
    output logic               empty,
    input  logic               pop
);

    import dtfp_pkg::*;

    cmd_t    front_cmd;
    cmd_t    head_cmd;
    logic    front_push;
    logic    cmd_full;
    logic    cmd_empty;
    logic    cmd_pop;
    result_t back_res;
    result_t head_res;
    logic    res_push;
    logic    res_full;

    dtfp_front u_front (
        .character  (character),
        .char_valid (char_valid),
        .last_char  (last_char),
        .push       (push),
        .full       (full),
        .cmd_full   (cmd_full),
        .cmd_push   (front_push),
        .cmd        (front_cmd)
    );

    dtfp_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (head_cmd),
        .empty   (cmd_empty)
    );

    dtfp_back #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    dtfp_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (head_res),
        .empty   (empty)
    );

    // Apply sign and clamp to the oldest result
    always_comb
    begin
        if (head_res.overflowed)
        begin
            value = $signed(head_res.negative ? NEG_LIMIT : MAG_LIMIT);
        end
        else if (head_res.negative)
        begin
            value = $signed(NUM_W'(0) - head_res.magnitude);
        end
        else
        begin
            value = $signed(head_res.magnitude);
        end
        saturated = head_res.overflowed;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import dtfp_pkg::*;

    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int REPORT_MAX      = 10;

    typedef struct {
        logic [63:0] value;
        logic        saturated;
    } parsed_number_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic         [7:0] character  = 8'h00;
    logic               char_valid = 1'b0;
    logic               last_char  = 1'b0;
    logic               push       = 1'b0;
    logic               full;
    logic signed [63:0] value;
    logic               saturated;
    logic               empty;
    logic               pop        = 1'b0;

    // Shadow copy of the parser state
    phase_t      parse_ph     = PH_START;
    logic        minus_seen   = 1'b0;
    logic        is_negative  = 1'b0;
    logic [63:0] mag          = '0;
    logic [3:0]  frac_count   = '0;
    logic        clamped      = 1'b0;

    parsed_number_t expected_numbers[$];
    logic [7:0]     text_buf[$];

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int chars_sent    = 0;
    int mismatches    = 0;

    decimal_text_to_fixed_point #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .character  (character),
        .char_valid (char_valid),
        .last_char  (last_char),
        .push       (push),
        .full       (full),
        .value      (value),
        .saturated  (saturated),
        .empty      (empty),
        .pop        (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run in case the block hangs
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        logic [7:0] b;
        b = 8'($urandom_range(hi, lo));
        return b;
    endfunction

    // ---------------------------------------------------------------
    // Number parser prediction
    // ---------------------------------------------------------------

    function automatic logic [63:0] frac_weight(input int k);
        logic [63:0] w;
        w = 64'd1 << FRAC_BITS;
        for (int i = 0; i < k; i++)
            w = w / 64'd10;
        return w;
    endfunction

    function automatic void clear_parser();
        parse_ph    = PH_START;
        minus_seen  = 1'b0;
        is_negative = 1'b0;
        mag         = '0;
        frac_count  = '0;
        clamped     = 1'b0;
    endfunction

    function automatic void add_int_digit(input logic [63:0] d);
        logic [63:0] add;
        add = d << FRAC_BITS;
        if (clamped || mag > (MAG_LIMIT - add) / 64'd10)
        begin
            mag     = MAG_LIMIT;
            clamped = 1'b1;
        end
        else
            mag = mag * 64'd10 + add;
    endfunction

    function automatic void add_frac_digit(input logic [63:0] d);
        logic [63:0] w;
        if (frac_count >= MAX_FRAC_DIGITS)
            return;
        frac_count = frac_count + 4'd1;
        w = d * frac_weight(frac_count);
        if (clamped || mag > MAG_LIMIT - w)
        begin
            mag     = MAG_LIMIT;
            clamped = 1'b1;
        end
        else
            mag = mag + w;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic        numeral;
        logic [63:0] d;
        numeral = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = '0;
        if (numeral)
            d[3:0] = c[3:0];
        case (parse_ph)
            PH_START:
            begin
                if (numeral)
                begin
                    parse_ph = PH_INT;
                    add_int_digit(d);
                end
                else if (c == CHAR_MINUS)
                begin
                    minus_seen = 1'b1;
                    parse_ph   = PH_INT;
                end
                else if (c == CHAR_DOT)
                    parse_ph = PH_FRAC;
                else
                    parse_ph = PH_STOP;
            end
            PH_INT:
            begin
                if (numeral)
                begin
                    if (minus_seen)
                    begin
                        is_negative = 1'b1;
                        minus_seen  = 1'b0;
                    end
                    add_int_digit(d);
                end
                else if (c == CHAR_DOT && !minus_seen)
                    parse_ph = PH_FRAC;
                else
                    parse_ph = PH_STOP;
            end
            PH_FRAC:
            begin
                if (numeral)
                    add_frac_digit(d);
                else
                    parse_ph = PH_STOP;
            end
            default: ;
        endcase
    endfunction

    // Advance the shadow parser by one accepted item; queue the number on last
    function automatic void predict_item(input logic [7:0] c, input logic vld,
                                         input logic lst);
        parsed_number_t n;
        if (vld)
            take_char(c);
        if (lst)
        begin
            if (clamped)
                n.value = is_negative ? NEG_LIMIT : MAG_LIMIT;
            else
                n.value = is_negative ? (64'd0 - mag) : mag;
            n.saturated = clamped;
            expected_numbers.push_back(n);
            clear_parser();
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking and pop control
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic exp_s);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch (%s): value exp %h got %h, saturated exp %b got %b",
                     what, exp_v, value, exp_s, saturated);
    endtask

    always @(posedge clk)
    begin
        parsed_number_t n;
        if (rst_n && pop && !empty)
        begin
            if (expected_numbers.size() == 0)
                report_mismatch("no number expected", 'x, 1'bx);
            else
            begin
                n = expected_numbers.pop_front();
                if (value !== n.value || saturated !== n.saturated)
                    report_mismatch("wrong field", n.value, n.saturated);
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Hold one character until its transfer, then idle at random
    task automatic send_item(input logic [7:0] c, input logic vld, input logic lst);
        character  <= c;
        char_valid <= vld;
        last_char  <= lst;
        push       <= 1'b1;
        do
            @(posedge clk);
        while (full);
        predict_item(c, vld, lst);
        if (vld)
            chars_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Send text_buf as one string; noisy adds ignored items and invalid endings
    task automatic send_buffer(input bit noisy);
        bit tail_invalid;
        tail_invalid = noisy && ($urandom_range(99) < 10);
        if (text_buf.size() == 0)
            send_item(rand_byte(0, 255), 1'b0, 1'b1);
        else
        begin
            for (int i = 0; i < text_buf.size(); i++)
            begin
                if (noisy && $urandom_range(99) < 5)
                    send_item(rand_byte(0, 255), 1'b0, 1'b0);
                send_item(text_buf[i], 1'b1, (i == text_buf.size() - 1) && !tail_invalid);
            end
            if (tail_invalid)
                send_item(rand_byte(0, 255), 1'b0, 1'b1);
        end
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buffer(1'b0);
    endtask

    // Mostly well-formed numbers with random digits, some noise and garbage
    task automatic build_random_text();
        int kind;
        int r;
        int n;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            n = $urandom_range(4, 1);
            repeat (n) text_buf.push_back(rand_byte(0, 255));
        end
        else
        begin
            if ($urandom_range(99) < 30)
                text_buf.push_back(CHAR_MINUS);
            r = $urandom_range(99);
            n = (r < 10) ? $urandom_range(13, 9) : ((r < 20) ? 0 : $urandom_range(5, 1));
            repeat (n) text_buf.push_back(rand_byte(CHAR_ZERO, CHAR_NINE));
            if ($urandom_range(99) < 60)
            begin
                text_buf.push_back(CHAR_DOT);
                r = $urandom_range(99);
                n = (r < 12) ? $urandom_range(13, 9) : $urandom_range(4, 0);
                repeat (n) text_buf.push_back(rand_byte(CHAR_ZERO, CHAR_NINE));
            end
            if ($urandom_range(99) < 15)
            begin
                r = $urandom_range(5);
                case (r)
                    0: text_buf.push_back(CHAR_MINUS);
                    1: text_buf.push_back(CHAR_DOT);
                    2: text_buf.push_back(CHAR_ZERO - 8'd1);
                    3: text_buf.push_back(CHAR_NINE + 8'd1);
                    default: text_buf.push_back(rand_byte(0, 255));
                endcase
                n = $urandom_range(2, 0);
                repeat (n) text_buf.push_back(rand_byte(CHAR_ZERO, CHAR_NINE));
            end
        end
    endtask

    // Stop sending until every number has come out, then let the block settle
    task automatic drain_results();
        push <= 1'b0;
        while (expected_numbers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_special_cases();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        // empty string
        send_item(8'hA5, 1'b0, 1'b1);
        // lone minus, minus followed by dot
        send_text("-");
        send_text("-.5");
        // leading dot
        send_text(".5");
        // negative overflow, then digits past the fraction limit
        send_text("-9999999999");
        send_text(".12345678901");
        // ignored item inside a string, top-bit byte stops parsing
        send_item("7", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_random_numbers(input int idle_pct, input int stall_pct,
                                       input int char_count);
        int stop_at;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        stop_at = chars_sent + char_count;
        while (chars_sent < stop_at)
        begin
            build_random_text();
            send_buffer(1'b1);
        end
    endtask

    task automatic test_pause_until_drained();
        int n;
        send_idle_pct = 7;
        pop_stall_pct = 7;
        repeat (4)
        begin
            n = $urandom_range(4, 2);
            repeat (n)
            begin
                build_random_text();
                send_buffer(1'b1);
            end
            drain_results();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random_numbers(0, 0, 300);
        test_random_numbers(70, 0, 300);
        test_random_numbers(0, 70, 300);
        test_random_numbers(7, 7, 300);
        test_pause_until_drained();

        drain_results();
        if (mismatches == 0 && expected_numbers.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dtfp_pkg.sv
rtl/dtfp_queue.sv
rtl/dtfp_front.sv
rtl/dtfp_back.sv
rtl/decimal_text_to_fixed_point.sv
sim/tb_top.sv
